// ===== rtl/hse_pkg.sv =====
// hse_pkg: shared types for the heap sort engine.
// Sequencer state encoding and the status group from sequencer to top level.
// No dependencies.
package hse_pkg;

  // Sequencer states, one-hot
  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_SD_START = 13'b0000000000010,
    S_SD_HELD  = 13'b0000000000100,
    S_SD_NEXT  = 13'b0000000001000,
    S_SD_LEFT  = 13'b0000000010000,
    S_SD_RIGHT = 13'b0000000100000,
    S_SD_CMP   = 13'b0000001000000,
    S_SD_WRITE = 13'b0000010000000,
    S_SW_RD0   = 13'b0000100000000,
    S_SW_RDE   = 13'b0001000000000,
    S_SW_WR    = 13'b0010000000000,
    S_OUT_RD   = 13'b0100000000000,
    S_OUT_CAP  = 13'b1000000000000
  } hse_state_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic busy;      // sort or readout in progress
    logic res_we;    // RAM read data is the next result this cycle
    logic res_last;  // that result closes the batch
  } hse_stat_t;

endpackage

// ===== rtl/hse_ram.sv =====
// hse_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module hse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== rtl/hse_seq.sv =====
// hse_seq: heap sort sequencer with one shared signed comparator.
// Drives the RAM through hse_ram ports; uses hse_pkg types.
module hse_seq
  import hse_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  logic                         out_free,
  input  logic [DATA_WIDTH-1:0]        rd_data,
  output logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic                         wr_en,
  output logic [$clog2(DEPTH)-1:0]     wr_addr,
  output logic [DATA_WIDTH-1:0]        wr_data,
  output hse_stat_t                    stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = AW + 2;

  hse_state_t state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] size_r, size_nxt;
  logic [CW-1:0] bi_r, bi_nxt;
  logic [AW-1:0] parent_r, parent_nxt;
  logic [AW-1:0] child_r, child_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic          sorting_r, sorting_nxt;
  logic [DATA_WIDTH-1:0] held_r, held_nxt;
  logic [DATA_WIDTH-1:0] cval_r, cval_nxt;
  logic [DATA_WIDTH-1:0] tmp_r, tmp_nxt;

  logic [LW-1:0] lft, rgt, size_x;
  logic [DATA_WIDTH-1:0] cmp_a, cmp_b;
  logic gt;
  logic k_last;

  assign lft    = {1'b0, parent_r, 1'b1};
  assign rgt    = lft + LW'(1);
  assign size_x = LW'(size_r);
  assign k_last = (CW'(k_r) + CW'(1)) == n_r;

  // shared compare: right vs left child, then best child vs held value
  assign cmp_a = (state_r == S_SD_RIGHT) ? rd_data : cval_r;
  assign cmp_b = (state_r == S_SD_RIGHT) ? cval_r  : held_r;
  assign gt    = $signed(cmp_a) > $signed(cmp_b);

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    size_nxt    = size_r;
    bi_nxt      = bi_r;
    parent_nxt  = parent_r;
    child_nxt   = child_r;
    end_nxt     = end_r;
    k_nxt       = k_r;
    sorting_nxt = sorting_r;
    held_nxt    = held_r;
    cval_nxt    = cval_r;
    tmp_nxt     = tmp_r;
    rd_addr     = parent_r;
    wr_en       = 1'b0;
    wr_addr     = parent_r;
    wr_data     = held_r;
    stat.busy     = (state_r != S_IDLE);
    stat.res_we   = 1'b0;
    stat.res_last = k_last;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          n_nxt = count;
          k_nxt = '0;
          if (count < CW'(2)) begin
            state_nxt = S_OUT_RD;
          end else begin
            bi_nxt      = count >> 1;
            parent_nxt  = AW'((count >> 1) - CW'(1));
            size_nxt    = count;
            sorting_nxt = 1'b0;
            state_nxt   = S_SD_START;
          end
        end
      end
      S_SD_START: begin
        rd_addr   = parent_r;
        state_nxt = S_SD_HELD;
      end
      S_SD_HELD: begin
        held_nxt  = rd_data;
        state_nxt = S_SD_NEXT;
      end
      S_SD_NEXT: begin
        rd_addr = lft[AW-1:0];
        if (lft < size_x) begin
          state_nxt = S_SD_LEFT;
        end else begin
          state_nxt = S_SD_WRITE;
        end
      end
      S_SD_LEFT: begin
        cval_nxt  = rd_data;
        child_nxt = lft[AW-1:0];
        rd_addr   = rgt[AW-1:0];
        if (rgt < size_x) begin
          state_nxt = S_SD_RIGHT;
        end else begin
          state_nxt = S_SD_CMP;
        end
      end
      S_SD_RIGHT: begin
        if (gt) begin
          cval_nxt  = rd_data;
          child_nxt = rgt[AW-1:0];
        end
        state_nxt = S_SD_CMP;
      end
      S_SD_CMP: begin
        if (gt) begin
          wr_en      = 1'b1;
          wr_addr    = parent_r;
          wr_data    = cval_r;
          parent_nxt = child_r;
          state_nxt  = S_SD_NEXT;
        end else begin
          state_nxt = S_SD_WRITE;
        end
      end
      S_SD_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = parent_r;
        wr_data = held_r;
        if (!sorting_r) begin
          if (bi_r > CW'(1)) begin
            bi_nxt     = bi_r - CW'(1);
            parent_nxt = AW'(bi_r - CW'(2));
            state_nxt  = S_SD_START;
          end else begin
            end_nxt     = AW'(n_r - CW'(1));
            sorting_nxt = 1'b1;
            state_nxt   = S_SW_RD0;
          end
        end else begin
          if (end_r > AW'(1)) begin
            end_nxt   = end_r - AW'(1);
            state_nxt = S_SW_RD0;
          end else begin
            state_nxt = S_OUT_RD;
          end
        end
      end
      S_SW_RD0: begin
        rd_addr   = '0;
        state_nxt = S_SW_RDE;
      end
      S_SW_RDE: begin
        tmp_nxt   = rd_data;
        rd_addr   = end_r;
        state_nxt = S_SW_WR;
      end
      S_SW_WR: begin
        // old root goes to the end, old end value sifts down from the root
        held_nxt   = rd_data;
        wr_en      = 1'b1;
        wr_addr    = end_r;
        wr_data    = tmp_r;
        parent_nxt = '0;
        size_nxt   = CW'(end_r);
        state_nxt  = S_SD_NEXT;
      end
      S_OUT_RD: begin
        rd_addr = k_r;
        if (out_free) begin
          state_nxt = S_OUT_CAP;
        end
      end
      S_OUT_CAP: begin
        stat.res_we = 1'b1;
        k_nxt       = k_r + AW'(1);
        if (k_last) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_OUT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    n_r       <= n_nxt;
    size_r    <= size_nxt;
    bi_r      <= bi_nxt;
    parent_r  <= parent_nxt;
    child_r   <= child_nxt;
    end_r     <= end_nxt;
    k_r       <= k_nxt;
    sorting_r <= sorting_nxt;
    held_r    <= held_nxt;
    cval_r    <= cval_nxt;
    tmp_r     <= tmp_nxt;
  end

endmodule

// ===== rtl/heap_sort_engine.sv =====
// heap_sort_engine: top level, batch load, output register, RAM write mux.
// Instantiates hse_ram and hse_seq; uses hse_pkg.
//
//  channel | ports                                         | dir
//  --------+-----------------------------------------------+-----
//  input   | in_valid, in_ready, in_item_value, in_is_last | in
//  result  | out_valid, out_ready, out_sorted_value,       | out
//          | out_last_result, out_overflow                 |
//
// Loads take one request per cycle while in_ready is high; each value that fits
// is written straight to the RAM. A request with in_is_last starts the sort;
// in_ready stays low until the last result of the batch sits in the output
// register. Heapify and sort use a single RAM read port and one compare unit.
// In readout the output register must empty before the next RAM word is
// captured.
// Reset (rst_n low, synchronous) clears the load count, overflow flag, the
// sequencer and the output valid. A stalled out_ready holds the readout.
module heap_sort_engine
  import hse_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] in_item_value,
  input  logic                  in_is_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_sorted_value,
  output logic                  out_last_result,
  output logic                  out_overflow
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          dropped_r, dropped_nxt;
  logic          batch_ovf_r, batch_ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_value_r;
  logic          out_last_r, out_ovf_r;

  logic          in_acc, full, start;
  logic          ld_we;
  hse_stat_t     stat;
  logic [AW-1:0] seq_rd_addr, seq_wr_addr, ram_wr_addr;
  logic          seq_wr_en, ram_wr_en;
  logic [DATA_WIDTH-1:0] seq_wr_data, ram_wr_data, ram_rd_data;

  assign in_ready = !stat.busy;
  assign in_acc   = in_valid && in_ready;
  assign full     = (count_r == CW'(DEPTH));
  assign ld_we    = in_acc && !full;
  assign start    = in_acc && in_is_last;

  // load phase owns the write port until the sequencer is busy
  assign ram_wr_en   = stat.busy ? seq_wr_en   : ld_we;
  assign ram_wr_addr = stat.busy ? seq_wr_addr : count_r[AW-1:0];
  assign ram_wr_data = stat.busy ? seq_wr_data : in_item_value;

  always_comb begin
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    batch_ovf_nxt = batch_ovf_r;
    if (in_acc) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
      end
      if (in_is_last) begin
        // batch closes: hand the count over, start the next batch clean
        batch_ovf_nxt = dropped_nxt;
        count_nxt     = '0;
        dropped_nxt   = 1'b0;
      end
    end
  end

  // count handed to the sequencer includes this last request's own load
  logic [CW-1:0] start_count;
  assign start_count = full ? count_r : count_r + CW'(1);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (stat.res_we) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dropped_r   <= 1'b0;
      batch_ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      batch_ovf_r <= batch_ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (stat.res_we) begin
      out_value_r <= ram_rd_data;
      out_last_r  <= stat.res_last;
      out_ovf_r   <= batch_ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_result  = out_last_r;
  assign out_overflow     = out_ovf_r;

  hse_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (ram_wr_en),
    .wr_addr   (ram_wr_addr),
    .wr_data   (ram_wr_data),
    .rd_addr   (seq_rd_addr),
    .rd_data_r (ram_rd_data)
  );

  hse_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .count    (start_count),
    .out_free (!out_valid_r),
    .rd_data  (ram_rd_data),
    .rd_addr  (seq_rd_addr),
    .wr_en    (seq_wr_en),
    .wr_addr  (seq_wr_addr),
    .wr_data  (seq_wr_data),
    .stat     (stat)
  );

endmodule

// ===== bench/tb_heap_sort_engine.sv =====
// tb_heap_sort_engine: self-checking bench for the heap sort engine.
// Drives batches of signed values and checks each sorted readout against a predictor.
// Depends on rtl/heap_sort_engine.sv (and hse_pkg through it).
module tb_heap_sort_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW    = 32;
  localparam int DEPTH = 64;
  // generous: well above the slowest correct run
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 200;

  localparam logic [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};

  // one sorted value as it leaves the block
  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 last;
    logic                 ovf;
  } sorted_res_t;

  // directed stimulus row; exp_value is only used where typed is set
  typedef struct packed {
    logic [DW-1:0] value;
    logic          last;
    logic          typed;
    logic [DW-1:0] exp_value;
  } dir_row_t;

  localparam int N_DIR = 23;
  localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
    // single-value batches straight after reset: result equals the value
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{VAL_MAX,       1'b1, 1'b1, VAL_MAX},
    '{VAL_MIN,       1'b1, 1'b1, VAL_MIN},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    // extremes mixed with values around zero
    '{VAL_MAX,       1'b0, 1'b0, '0},
    '{VAL_MIN,       1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'h0000_0001, 1'b1, 1'b0, '0},
    // repeated values must come out side by side
    '{32'h0000_0005, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFB, 1'b0, 1'b0, '0},
    '{32'h0000_0005, 1'b0, 1'b0, '0},
    '{32'h0000_0005, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFB, 1'b1, 1'b0, '0},
    // two values in falling order
    '{32'h0000_0064, 1'b0, 1'b0, '0},
    '{32'hFFFF_FF9C, 1'b1, 1'b0, '0},
    // odd-sized batch, already ascending, checkerboard bit patterns at the ends
    '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFE, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'h0000_0002, 1'b0, 1'b0, '0},
    '{32'h0000_0003, 1'b0, 1'b0, '0},
    '{32'h1234_5678, 1'b0, 1'b0, '0},
    '{32'h5555_5555, 1'b1, 1'b0, '0}
  };

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [DW-1:0] in_item_value = '0;
  logic          in_is_last = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [DW-1:0] out_sorted_value;
  logic          out_last_result;
  logic          out_overflow;

  // predictor state: values of the open batch kept in ascending order
  logic signed [DW-1:0] loaded_vals [$];
  logic                 batch_dropped = 1'b0;
  sorted_res_t          pending_sorted [$];

  int errors = 0;
  int cycle_cnt = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_len = 0;

  heap_sort_engine #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item_value(in_item_value),
    .in_is_last(in_is_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sorted_value(out_sorted_value),
    .out_last_result(out_last_result),
    .out_overflow(out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random backpressure, or a long hold when the main flow asks for one.
  // The hold is counted down here so the sender keeps running meanwhile.
  always @(negedge clk) begin
    if (hold_len > 0) begin
      out_ready = 1'b0;
      hold_len--;
    end else begin
      out_ready = ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Result checker: every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    sorted_res_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sorted.size() == 0) begin
        $display("%0t: unexpected result value %0d last %0b ovf %0b", $time,
                 $signed(out_sorted_value), out_last_result, out_overflow);
        errors++;
      end else begin
        exp_res = pending_sorted.pop_front();
        if (out_sorted_value !== exp_res.value) begin
          $display("%0t: sorted_value mismatch exp %0d got %0d", $time,
                   exp_res.value, $signed(out_sorted_value));
          errors++;
        end
        if (out_last_result !== exp_res.last) begin
          $display("%0t: last_result mismatch exp %0b got %0b", $time,
                   exp_res.last, out_last_result);
          errors++;
        end
        if (out_overflow !== exp_res.ovf) begin
          $display("%0t: overflow mismatch exp %0b got %0b", $time,
                   exp_res.ovf, out_overflow);
          errors++;
        end
      end
    end
  end

  // Predictor for one accepted request. Values go into the batch in sorted
  // position; loads past DEPTH are dropped and mark the batch. On the last
  // request the whole batch becomes expected results, ascending.
  function automatic void load_value(input logic signed [DW-1:0] v, input logic l);
    int pos;
    pos = 0;
    if (loaded_vals.size() < DEPTH) begin
      while (pos < loaded_vals.size() && loaded_vals[pos] <= v)
        pos++;
      loaded_vals.insert(pos, v);
    end else begin
      batch_dropped = 1'b1;
    end
    if (l) begin
      foreach (loaded_vals[k])
        pending_sorted.push_back('{loaded_vals[k], (k == loaded_vals.size() - 1),
                                   batch_dropped});
      loaded_vals.delete();
      batch_dropped = 1'b0;
    end
  endfunction

  // Offer one request. Entered and left at a falling edge. A typed row
  // replaces the predicted single result with the value written in the table.
  task automatic send_req(input logic [DW-1:0] v, input logic l,
                          input logic typed, input logic [DW-1:0] exp_v);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_item_value = v;
    in_is_last    = l;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (typed) begin
      loaded_vals.delete();
      batch_dropped = 1'b0;
      pending_sorted.push_back('{exp_v, 1'b1, 1'b0});
    end else begin
      load_value(v, l);
    end
    @(negedge clk);
  endtask

  // Random value: extremes, a narrow band around zero for repeats, or anything.
  function automatic logic [DW-1:0] rand_value();
    case ($urandom_range(9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3: return DW'($signed($urandom_range(15)) - 8);
      default: return DW'($urandom);
    endcase
  endfunction

  initial begin
    int rnd_items;
    int batch_no;
    int batch_len;

    // hold reset, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part, under the first idling mix
    in_idle_pct   = 26;
    out_stall_pct = 58;
    for (int r = 0; r < N_DIR; r++)
      send_req(DIR_ROWS[r].value, DIR_ROWS[r].last, DIR_ROWS[r].typed,
               DIR_ROWS[r].exp_value);

    // random batches: mostly short, one exactly full, one that overruns the store
    rnd_items = 0;
    batch_no  = 0;
    while (rnd_items < RANDOM_ITEMS) begin
      if (rnd_items < RANDOM_ITEMS / 3) begin
        in_idle_pct   = 26;
        out_stall_pct = 58;
      end else if (rnd_items < 2 * RANDOM_ITEMS / 3) begin
        in_idle_pct   = 58;
        out_stall_pct = 26;
      end else begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end

      case (batch_no)
        2: batch_len = DEPTH;
        5: batch_len = DEPTH + $urandom_range(1, 4);
        default: batch_len = $urandom_range(1, 10);
      endcase

      // long receiver hold: readout stalls and the next batch backs up at the input
      if (batch_no == 4)
        hold_len = 400;
      // sender drains fully before this batch, offering nothing meanwhile
      if (batch_no == 7) begin
        in_valid = 1'b0;
        while (pending_sorted.size() != 0) @(negedge clk);
      end

      for (int k = 0; k < batch_len; k++) begin
        send_req(rand_value(), (k == batch_len - 1), 1'b0, '0);
        rnd_items++;
      end
      batch_no++;
    end

    in_valid   = 1'b0;
    in_is_last = 1'b0;

    // drain, then a short quiet window for any stray result
    while (pending_sorted.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);

    if (errors == 0 && pending_sorted.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
